// File: src/udpcs_pkg.sv
// ----------------------------------------------------------------------------
// udpcs_pkg
// Shared types and constants for the UDP checksum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package udpcs_pkg;

  // Protocol constants
  localparam logic [15:0] UDP_PROTO    = 16'd17;
  localparam logic [15:0] HDR_BYTES    = 16'd8;
  localparam logic [15:0] MAX_PAYLOAD  = 16'd65507;
  // Largest header length whose payload still fits in transmit
  localparam logic [15:0] MAX_TX_LEN   = MAX_PAYLOAD + HDR_BYTES;
  localparam logic [31:0] DEF_SRC_ADDR = 32'h0A00_0004;

  // Header field byte offsets
  localparam logic [15:0] OFS_DST_PORT = 16'd2;
  localparam logic [15:0] OFS_LENGTH   = 16'd4;
  localparam logic [15:0] OFS_CHECKSUM = 16'd6;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_LEN   = 2'd1,
    STAT_MISMATCH  = 2'd2,
    STAT_PORT_ZERO = 2'd3
  } status_t;

  typedef enum logic {
    DIR_TX = 1'b0,
    DIR_RX = 1'b1
  } dir_t;

  // One input beat
  typedef struct packed {
    logic        direction;
    logic        first;
    logic        last;
    logic [15:0] data_word;
    logic [1:0]  bytes_in_word;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] ip_payload_length;
  } beat_t;

  // One result
  typedef struct packed {
    status_t     status;
    logic [15:0] checksum;
    logic [15:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

// File: src/udpcs_in_if.sv
// ----------------------------------------------------------------------------
// udpcs_in_if
// Input word channel: valid/ready handshake with one datagram word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface udpcs_in_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic        first;
  logic        last;
  logic [15:0] data_word;
  logic [1:0]  bytes_in_word;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] ip_payload_length;

  modport source (
    output valid, direction, first, last, data_word, bytes_in_word,
           source_address, dest_address, ip_payload_length,
    input  ready
  );

  modport sink (
    input  valid, direction, first, last, data_word, bytes_in_word,
           source_address, dest_address, ip_payload_length,
    output ready
  );
endinterface

`default_nettype wire

// File: src/udpcs_out_if.sv
// ----------------------------------------------------------------------------
// udpcs_out_if
// Result channel: valid/ready handshake with one datagram result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface udpcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] checksum;
  logic [15:0] payload_length;

  modport source (
    output valid, status, checksum, payload_length,
    input  ready
  );

  modport sink (
    input  valid, status, checksum, payload_length,
    output ready
  );
endinterface

`default_nettype wire

// File: src/udpcs_core.sv
// ----------------------------------------------------------------------------
// udpcs_core
// Datagram state and the combinational ones'-complement update for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module udpcs_core
  import udpcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire beat_t       beat,
  input  wire logic [31:0] def_src_addr,
  output      result_t     res
);

  logic [15:0] running_sum_r, running_sum_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] header_length_r, header_length_nxt;
  logic [15:0] received_check_r, received_check_nxt;
  logic        port_zero_r, port_zero_nxt;
  logic [15:0] ip_bound_r, ip_bound_nxt;

  logic [15:0] sum_base, hl_cur, rc_cur, pos, v, len_add;
  logic        pz_cur, two_bytes;
  logic [31:0] sa_eff, da_eff;
  logic [15:0] proto_add;
  logic [18:0] sum_wide;
  logic [16:0] fold1, nc;
  logic [15:0] cs_raw;
  logic        len_ok;

  // Start from cleared state on a first word, else continue
  always_comb begin
    sum_base  = beat.first ? '0 : running_sum_r;
    hl_cur    = beat.first ? '0 : header_length_r;
    rc_cur    = beat.first ? '0 : received_check_r;
    pz_cur    = beat.first ? 1'b0 : port_zero_r;
    pos       = beat.first ? '0 : byte_count_r;
    two_bytes = (beat.bytes_in_word != 2'd1);
    if (beat.first && beat.direction == DIR_TX && beat.source_address == '0) begin
      sa_eff = def_src_addr;
    end else begin
      sa_eff = beat.source_address;
    end
    da_eff    = beat.first ? beat.dest_address : '0;
    sa_eff    = beat.first ? sa_eff : '0;
    proto_add = beat.first ? UDP_PROTO : '0;
    ip_bound_nxt = beat.first ? beat.ip_payload_length : ip_bound_r;
  end

  // Recognise header fields and mask the summed word
  always_comb begin
    v                  = two_bytes ? beat.data_word : {beat.data_word[15:8], 8'h00};
    len_add            = '0;
    header_length_nxt  = hl_cur;
    received_check_nxt = rc_cur;
    port_zero_nxt      = pz_cur;
    if (two_bytes && pos == OFS_DST_PORT) begin
      port_zero_nxt = (beat.data_word == '0);
    end
    if (two_bytes && pos == OFS_LENGTH) begin
      header_length_nxt = beat.data_word;
      len_add           = beat.data_word;
    end
    if (two_bytes && pos == OFS_CHECKSUM) begin
      received_check_nxt = beat.data_word;
      if (beat.direction == DIR_TX) begin
        v = '0;
      end
    end
    // Drop bytes beyond the datagram length
    if (pos >= OFS_CHECKSUM) begin
      if (pos >= hl_cur) begin
        v = '0;
      end else if (({1'b0, pos} + 17'd1) >= {1'b0, hl_cur}) begin
        v = {v[15:8], 8'h00};
      end
    end
  end

  // Sum all operands wide, then fold the carries back in twice
  always_comb begin
    sum_wide = 19'(sum_base) + 19'(sa_eff[31:16]) + 19'(sa_eff[15:0])
             + 19'(da_eff[31:16]) + 19'(da_eff[15:0]) + 19'(proto_add)
             + 19'(len_add) + 19'(v);
    fold1           = {1'b0, sum_wide[15:0]} + {14'b0, sum_wide[18:16]};
    running_sum_nxt = 16'(fold1[15:0] + {15'b0, fold1[16]});
    nc              = {1'b0, pos} + (two_bytes ? 17'd2 : 17'd1);
    byte_count_nxt  = nc[16] ? 16'hffff : nc[15:0];
  end

  // Build the result for a last word
  always_comb begin
    cs_raw = ~running_sum_nxt;
    res    = '0;
    if (beat.direction == DIR_TX) begin
      len_ok = (header_length_nxt >= HDR_BYTES) && (header_length_nxt <= MAX_TX_LEN);
      if (port_zero_nxt) begin
        res.status = STAT_PORT_ZERO;
      end else if (!len_ok) begin
        res.status = STAT_BAD_LEN;
      end else begin
        res.status = STAT_OK;
      end
      res.checksum = (cs_raw == '0) ? 16'hffff : cs_raw;
    end else begin
      len_ok = (header_length_nxt >= HDR_BYTES) && (header_length_nxt <= ip_bound_nxt);
      if (!len_ok) begin
        res.status = STAT_BAD_LEN;
      end else if (received_check_nxt != '0 && cs_raw != '0) begin
        res.status = STAT_MISMATCH;
      end else begin
        res.status = STAT_OK;
      end
      res.checksum = cs_raw;
    end
    res.payload_length = len_ok ? 16'(header_length_nxt - HDR_BYTES) : '0;
  end

  // Advance datagram state on each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r    <= '0;
      byte_count_r     <= '0;
      header_length_r  <= '0;
      received_check_r <= '0;
      port_zero_r      <= 1'b0;
      ip_bound_r       <= '0;
    end else if (step_en) begin
      running_sum_r    <= running_sum_nxt;
      byte_count_r     <= byte_count_nxt;
      header_length_r  <= header_length_nxt;
      received_check_r <= received_check_nxt;
      port_zero_r      <= port_zero_nxt;
      ip_bound_r       <= ip_bound_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/udp_checksum_engine_unit.sv
// ----------------------------------------------------------------------------
// udp_checksum_engine_unit
// UDP checksum generation and verification over a stream of 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one big-endian word of UDP header and payload per beat,
//   with first/last marks, byte count and the pseudo-header addresses.
//   out_ch returns one result beat (status, checksum, payload length) for
//   each input beat marked last; other beats give no result.
//   cfg_wr_en/cfg_wr_data write the default source address, used in
//   transmit when the source address input is zero. Write only when idle.
// Timing:
//   A beat is captured in an input register, then the ones'-complement
//   update and result logic run combinationally into the output register;
//   a last beat's result is loaded once out_ch can take it. One beat is
//   accepted every cycle unless a last beat is held by a stalled out_ch.
// Reset and stall:
//   Reset clears the datagram state and both registers, and restores the
//   default source address. While out_ch stalls, a last beat waits in the
//   input register and in_ch.ready drops; non-last beats keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_checksum_engine_unit
  import udpcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  udpcs_in_if.sink         in_ch,
  udpcs_out_if.source      out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  logic [31:0] def_src_addr_r;
  logic        s1_valid_r;
  beat_t       s1_beat_r;
  logic        s1_adv;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     core_res;
  logic        out_load;

  // Default source address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_src_addr_r <= DEF_SRC_ADDR;
    end else if (cfg_wr_en) begin
      def_src_addr_r <= cfg_wr_data;
    end
  end

  // Stage moves unless it holds a last beat and the output is blocked
  assign s1_adv      = s1_valid_r && (!s1_beat_r.last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign out_load    = s1_adv && s1_beat_r.last;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_beat_r.direction         <= in_ch.direction;
      s1_beat_r.first             <= in_ch.first;
      s1_beat_r.last              <= in_ch.last;
      s1_beat_r.data_word         <= in_ch.data_word;
      s1_beat_r.bytes_in_word     <= in_ch.bytes_in_word;
      s1_beat_r.source_address    <= in_ch.source_address;
      s1_beat_r.dest_address      <= in_ch.dest_address;
      s1_beat_r.ip_payload_length <= in_ch.ip_payload_length;
    end
  end

  udpcs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .beat         (s1_beat_r),
    .def_src_addr (def_src_addr_r),
    .res          (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.checksum       = out_res_r.checksum;
  assign out_ch.payload_length = out_res_r.payload_length;

`ifndef SYNTHESIS
  // A new result only comes from a last beat leaving the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_beat_r.last))
    else $error("result raised without a last beat");

  // A bad length never reports a payload length
  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == STAT_BAD_LEN) |-> (out_res_r.payload_length == '0))
    else $error("bad length with nonzero payload length");

  // A held beat blocks the input channel
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_ch.ready)
    else $error("input accepted while stage is held");
`endif

endmodule

`default_nettype wire

// File: bench/udpcs_checksum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpcs_checksum_checker
// Watches the word and result channels of the UDP checksum engine, folds
// every accepted word into its own ones'-complement datagram state and
// compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module udpcs_checksum_checker
  import udpcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  udpcs_in_if         in_ch,
  udpcs_out_if        out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          outstanding
);

  // Predicted datagram state
  logic [31:0] local_src;
  logic [15:0] run_sum;
  logic [15:0] seen_bytes;
  logic [15:0] hdr_len;
  logic [15:0] rx_check;
  logic        port_zero;
  logic [15:0] len_bound;
  int          errors;

  result_t     pending_results[$];

  // End-around-carry addition of two words
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Fold one accepted word into the state; queue a result on a last word
  task automatic fold_word(input beat_t w);
    logic [31:0] src;
    logic [15:0] val;
    logic [15:0] pos;
    logic [16:0] next_pos;
    logic [15:0] inv;
    logic        two_bytes;
    logic        len_ok;
    result_t     r;
    two_bytes = (w.bytes_in_word != 2'd1);
    // Start a new sum already holding the pseudo-header
    if (w.first) begin
      run_sum    = 16'h0;
      seen_bytes = 16'h0;
      hdr_len    = 16'h0;
      rx_check   = 16'h0;
      port_zero  = 1'b0;
      len_bound  = w.ip_payload_length;
      src        = w.source_address;
      if (w.direction == DIR_TX && src == 32'h0) begin
        src = local_src;
      end
      run_sum = ones_add(run_sum, src[31:16]);
      run_sum = ones_add(run_sum, src[15:0]);
      run_sum = ones_add(run_sum, w.dest_address[31:16]);
      run_sum = ones_add(run_sum, w.dest_address[15:0]);
      run_sum = ones_add(run_sum, UDP_PROTO);
    end
    pos = seen_bytes;
    val = two_bytes ? w.data_word : {w.data_word[15:8], 8'h00};
    // Pick out header fields, only from full words at their offsets
    if (two_bytes) begin
      if (pos == OFS_DST_PORT) begin
        port_zero = (w.data_word == 16'h0);
      end
      if (pos == OFS_LENGTH) begin
        hdr_len = w.data_word;
        run_sum = ones_add(run_sum, w.data_word);
      end
      if (pos == OFS_CHECKSUM) begin
        rx_check = w.data_word;
        if (w.direction == DIR_TX) begin
          val = 16'h0;
        end
      end
    end
    // Drop bytes past the header length
    if (pos >= OFS_CHECKSUM) begin
      if (pos >= hdr_len) begin
        val = 16'h0;
      end else if (pos + 16'd1 == hdr_len) begin
        val[7:0] = 8'h00;
      end
    end
    run_sum    = ones_add(run_sum, val);
    next_pos   = {1'b0, pos} + (two_bytes ? 17'd2 : 17'd1);
    seen_bytes = next_pos[16] ? 16'hffff : next_pos[15:0];

    if (w.last) begin
      inv = ~run_sum;
      if (w.direction == DIR_TX) begin
        len_ok = (hdr_len >= HDR_BYTES) && (hdr_len <= MAX_TX_LEN);
        if (port_zero) begin
          r.status = STAT_PORT_ZERO;
        end else if (!len_ok) begin
          r.status = STAT_BAD_LEN;
        end else begin
          r.status = STAT_OK;
        end
        if (inv == 16'h0) begin
          inv = 16'hffff;
        end
      end else begin
        len_ok = (hdr_len >= HDR_BYTES) && (hdr_len <= len_bound);
        if (!len_ok) begin
          r.status = STAT_BAD_LEN;
        end else if (rx_check != 16'h0 && inv != 16'h0) begin
          r.status = STAT_MISMATCH;
        end else begin
          r.status = STAT_OK;
        end
      end
      r.checksum       = inv;
      r.payload_length = len_ok ? hdr_len - HDR_BYTES : 16'h0;
      pending_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    beat_t   got_word;
    result_t want;
    if (!rst_n) begin
      local_src  = DEF_SRC_ADDR;
      run_sum    = 16'h0;
      seen_bytes = 16'h0;
      hdr_len    = 16'h0;
      rx_check   = 16'h0;
      port_zero  = 1'b0;
      len_bound  = 16'h0;
      errors     = 0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        local_src = cfg_wr_data;
      end
      // Compare a result beat with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d checksum %04h len %0d",
                   $time, out_ch.status, out_ch.checksum, out_ch.payload_length);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status != want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_ch.status);
            errors++;
          end
          if (out_ch.checksum != want.checksum) begin
            $display("%0t: checksum expected %04h, got %04h",
                     $time, want.checksum, out_ch.checksum);
            errors++;
          end
          if (out_ch.payload_length != want.payload_length) begin
            $display("%0t: payload length expected %0d, got %0d",
                     $time, want.payload_length, out_ch.payload_length);
            errors++;
          end
        end
      end
      // Advance the prediction on a word beat
      if (in_ch.valid && in_ch.ready) begin
        got_word.direction         = in_ch.direction;
        got_word.first             = in_ch.first;
        got_word.last              = in_ch.last;
        got_word.data_word         = in_ch.data_word;
        got_word.bytes_in_word     = in_ch.bytes_in_word;
        got_word.source_address    = in_ch.source_address;
        got_word.dest_address      = in_ch.dest_address;
        got_word.ip_payload_length = in_ch.ip_payload_length;
        fold_word(got_word);
      end
    end
    fail_count  <= errors;
    outstanding <= pending_results.size();
  end

endmodule

// File: bench/udp_checksum_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_checksum_engine_unit_tb
// Drives UDP datagrams, malformed word runs and stray words into the checksum
// engine under several idle and stall patterns and default source settings;
// the checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------

module udp_checksum_engine_unit_tb;
  import udpcs_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 185;

  // Ways of filling the checksum word
  localparam int CKS_GOOD   = 0;
  localparam int CKS_ZERO   = 1;
  localparam int CKS_RANDOM = 2;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic [31:0] cur_default;
  int          fail_count;
  int          outstanding;
  int          cycle_count;
  int          words_sent;
  int          idle_pct;
  int          stall_pct;

  udpcs_in_if  in_ch ();
  udpcs_out_if out_ch ();

  udp_checksum_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  udpcs_checksum_checker u_sum_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Stall the result channel at the current rate
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one word, idling at the current rate, and hold it until accepted
  task automatic send_word(input dir_t dir, input logic first, input logic last,
                           input logic [15:0] data, input logic [1:0] nbytes,
                           input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] ipl);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.direction         <= dir;
    in_ch.first             <= first;
    in_ch.last              <= last;
    in_ch.data_word         <= data;
    in_ch.bytes_in_word     <= nbytes;
    in_ch.source_address    <= src;
    in_ch.dest_address      <= dst;
    in_ch.ip_payload_length <= ipl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Build a datagram and send it word by word
  task automatic send_datagram(input dir_t dir, input logic [31:0] src,
                               input logic [31:0] dst, input logic [15:0] ipl,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [15:0] len_field, input int pay_bytes,
                               input int cks_mode);
    logic [15:0] words[$];
    logic [31:0] acc;
    logic [31:0] eff_src;
    logic [15:0] fix;
    logic [1:0]  nbytes;
    int          fix_at;
    bit          odd;
    bit          is_last;
    dir_t        word_dir;
    odd = (pay_bytes % 2) != 0;
    words.push_back(sport);
    words.push_back(dport);
    words.push_back(len_field);
    words.push_back(16'($urandom));
    for (int i = 0; i < pay_bytes; i += 2) words.push_back(16'($urandom));
    // Transmit needs a full last payload word to steer the sum
    if (dir == DIR_TX && cks_mode == CKS_GOOD && (odd || pay_bytes < 2)) begin
      cks_mode = CKS_RANDOM;
    end
    fix_at = (dir == DIR_TX) ? words.size() - 1 : 3;
    if (cks_mode == CKS_ZERO) begin
      words[3] = 16'h0;
    end
    // Make the receive sum verify, or the transmit checksum come out as zero
    if (cks_mode == CKS_GOOD) begin
      eff_src = (dir == DIR_TX && src == 32'h0) ? cur_default : src;
      acc = eff_src[31:16] + eff_src[15:0] + dst[31:16] + dst[15:0] + UDP_PROTO + len_field;
      words[fix_at] = 16'h0;
      foreach (words[i]) begin
        if (!(i == 3 && dir == DIR_TX)) begin
          acc += (odd && i == words.size() - 1) ? {words[i][15:8], 8'h00} : words[i];
        end
      end
      acc = acc[15:0] + acc[31:16];
      acc = acc[15:0] + acc[31:16];
      fix = ~acc[15:0];
      if (fix == 16'h0) begin
        fix = 16'hffff;
      end
      words[fix_at] = fix;
    end
    foreach (words[i]) begin
      is_last = (i == words.size() - 1);
      if (odd && is_last) begin
        nbytes = 2'd1;
      end else begin
        nbytes = ($urandom_range(9) != 0) ? 2'd2 : ($urandom_range(1) ? 2'd3 : 2'd0);
      end
      word_dir = ($urandom_range(49) == 0) ? dir_t'(~dir) : dir;
      if (i == 0) begin
        send_word(word_dir, 1'b1, is_last, words[i], nbytes, src, dst, ipl);
      end else begin
        send_word(word_dir, 1'b0, is_last, words[i], nbytes, $urandom, $urandom,
                  16'($urandom));
      end
    end
  endtask

  // Hold the input idle until every result is back and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_src(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_default = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed datagrams with random faults, plus broken runs and stray words
  task automatic run_phase(input int idle, input int stall, input int count);
    int          stop_at;
    int          pick;
    int          roll;
    int          pay;
    int          mode;
    int          run_len;
    dir_t        dir;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ipl;
    logic [15:0] dport;
    logic [15:0] len_field;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        dir = dir_t'($urandom_range(1));
        pay = ($urandom_range(19) == 0) ? $urandom_range(200, 41) : $urandom_range(40);
        src = $urandom;
        dst = $urandom;
        roll = $urandom_range(15);
        if (roll < 2) begin
          src = '0;
        end else if (roll == 2) begin
          src = '1;
        end
        roll = $urandom_range(15);
        if (roll == 0) begin
          dst = '0;
        end else if (roll == 1) begin
          dst = '1;
        end
        dport = ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom);
        // Mostly a true length; sometimes short, long, oversized or wild
        len_field = 16'(pay + 8);
        case ($urandom_range(19))
          0: len_field = 16'($urandom_range(7));
          1: len_field = 16'(pay + 8 - $urandom_range(4, 1));
          2: len_field = 16'(pay + 8 + $urandom_range(4, 1));
          3: len_field = MAX_TX_LEN + 16'($urandom_range(1));
          4: len_field = 16'($urandom);
          default: ;
        endcase
        ipl  = len_field;
        roll = $urandom_range(7);
        if (roll == 0) begin
          ipl = 16'($urandom);
        end else if (roll == 1) begin
          ipl = len_field - 16'd1;
        end
        roll = $urandom_range(19);
        mode = (roll < 14) ? CKS_GOOD : ((roll < 17) ? CKS_ZERO : CKS_RANDOM);
        send_datagram(dir, src, dst, ipl, 16'($urandom), dport, len_field, pay, mode);
      end else if (pick < 90) begin
        // Broken run: maybe no first word, odd byte counts anywhere
        run_len = $urandom_range(6, 1);
        for (int i = 0; i < run_len; i++) begin
          send_word(dir_t'($urandom_range(1)), (i == 0) && ($urandom_range(9) < 7),
                    i == run_len - 1, 16'($urandom), 2'($urandom_range(3)),
                    $urandom, $urandom, 16'($urandom));
        end
      end else begin
        send_word(dir_t'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  16'($urandom), 2'($urandom_range(3)), $urandom, $urandom,
                  16'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid             <= 1'b0;
    in_ch.direction         <= 1'b0;
    in_ch.first             <= 1'b0;
    in_ch.last              <= 1'b0;
    in_ch.data_word         <= 16'h0;
    in_ch.bytes_in_word     <= 2'd2;
    in_ch.source_address    <= 32'h0;
    in_ch.dest_address      <= 32'h0;
    in_ch.ip_payload_length <= 16'h0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 32'h0;
    rst_n       <= 1'b0;
    cur_default = DEF_SRC_ADDR;
    words_sent  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Transmit, zero source takes the reset default, destination port zero
    send_datagram(DIR_TX, 32'h0, 32'hffff_ffff, 16'h0, 16'hffff, 16'h0,
                  16'd8, 0, CKS_RANDOM);
    // Receive, verifying sum, odd payload ending in a one-byte word
    send_datagram(DIR_RX, 32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 16'hffff,
                  16'd11, 3, CKS_GOOD);
    // Receive, no checksum given, length beyond the IP payload length
    send_datagram(DIR_RX, 32'h1234_5678, 32'h9abc_def0, 16'd11, 16'h1111, 16'h2222,
                  16'd12, 4, CKS_ZERO);
    // Transmit whose checksum folds to zero and is sent as all ones
    send_datagram(DIR_TX, 32'h0a0b_0c0d, 32'hc0a8_0001, 16'h0, 16'h0400, 16'h0035,
                  16'd10, 2, CKS_GOOD);
    // Transmit at the largest payload, then one byte over
    send_datagram(DIR_TX, 32'h0102_0304, 32'h0506_0708, 16'h0, 16'h0001, 16'h0002,
                  MAX_TX_LEN, 0, CKS_RANDOM);
    send_datagram(DIR_TX, 32'h0102_0304, 32'h0506_0708, 16'h0, 16'h0001, 16'h0002,
                  MAX_TX_LEN + 16'd1, 0, CKS_RANDOM);
    // Datagram cut short before the length word
    send_word(DIR_RX, 1'b1, 1'b1, 16'hffff, 2'd2, 32'h0, 32'h0, 16'hffff);
    // Last word with no first word before it
    send_word(DIR_TX, 1'b0, 1'b1, 16'h0, 2'd1, 32'h0, 32'h0, 16'h0);
    settle();

    write_default_src(32'hffff_ffff);
    run_phase(0, 0, PHASE_WORDS);
    settle();

    write_default_src(32'h0);
    run_phase(56, 0, PHASE_WORDS);
    settle();
    write_default_src($urandom);
    run_phase(0, 56, PHASE_WORDS);
    settle();
    write_default_src($urandom);
    run_phase(16, 16, PHASE_WORDS);
    settle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
